FILE: rtl/assert_macros.svh
// assertion macros used by mtg_control
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication checked in the clock after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/mtg_pkg.sv
// shared types and constants of the mt19937 generator
// no dependencies
package mtg_pkg;
	localparam logic [1:0] OP_NEXT = 2'd0;
	localparam logic [1:0] OP_SEED = 2'd1;
	localparam logic [1:0] OP_SALT = 2'd2;

	localparam int unsigned N_WORDS = 624;
	localparam int unsigned M_OFF = 397;
	localparam logic [31:0] INIT_MULT = 32'd1812433253;
	localparam logic [31:0] MIX1_MULT = 32'd1664525;
	localparam logic [31:0] MIX2_MULT = 32'd1566083941;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C = 32'hefc60000;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] HIGH_BIT = 32'h80000000;

	// datapath operations
	typedef enum logic [2:0] {
		DOP_NONE  = 3'd0,
		DOP_SEED  = 3'd1,
		DOP_MIX1  = 3'd2,
		DOP_MIX2  = 3'd3,
		DOP_TWIST = 3'd4,
		DOP_W0    = 3'd5,
		DOP_KEY   = 3'd6,
		DOP_READ  = 3'd7
	} dp_op_t;

	typedef struct packed {
		dp_op_t      op;
		logic [9:0]  idx;
		logic [31:0] seed;
		logic [31:0] key_word;
		logic [9:0]  key_idx;
		logic [9:0]  j;
		logic        first;
	} dp_cmd_t;

	typedef struct packed {
		logic [31:0] rd_word;
	} dp_stat_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] twist(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] far);
		logic [31:0] y;
		y = (a & HIGH_BIT) | (b & ~HIGH_BIT);
		return far ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
	endfunction
endpackage

FILE: rtl/mt19937_generator.sv
// top level of the mt19937 generator
// depends on mtg_pkg, mtg_control, mtg_datapath, mtg_ram
//
// usage:
//   input channel: in_valid/in_ready with opcode, value, last_key.
//   opcode next returns one tempered word on the output channel
//   (out_valid/out_ready, random_word); seed and salt return nothing.
//   a next item shows its word on the output, and only then is the input
//   ready again; every 624 words the state is regenerated first.
//   a seed keeps the input busy for a full pass over the state words, a
//   final salt key for two mixing passes and the word 0 write, plus a
//   seed pass if never seeded. each state word step is read, compute, write
//   through the state memory; other items need no such step.
//   after reset the generator is unseeded; the first next or final salt
//   applies the default seed 5489 first.
//   a stalled output holds its word; a new item is taken only once the
//   output register is free or being taken in the same cycle.
module mt19937_generator #(
	parameter int KEY_MAX = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [31:0] value,
	input  logic        last_key,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] random_word
);
	mtg_pkg::dp_cmd_t  cmd;
	mtg_pkg::dp_stat_t stat;

	mtg_control #(.KEY_MAX(KEY_MAX)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .value, .last_key,
		.out_valid, .out_ready, .random_word, .cmd, .stat);

	mtg_datapath #(.KEY_MAX(KEY_MAX)) u_dp (
		.clk, .cmd, .stat);
endmodule

FILE: rtl/mtg_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mtg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 624
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/mtg_datapath.sv
// state memories and arithmetic of the mt19937 generator
// depends on mtg_pkg and mtg_ram
module mtg_datapath #(
	parameter int KEY_MAX = 16
) (
	input  logic             clk,
	input  mtg_pkg::dp_cmd_t cmd,
	output mtg_pkg::dp_stat_t stat
);
	localparam int KW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

	// three copies of the state so each step reads three words in the same cycle
	logic        we;
	logic [9:0]  waddr;
	logic [31:0] wdata;
	logic [9:0]  ra_a, ra_b, ra_c;
	logic [31:0] rd_a, rd_b, rd_c;
	logic [31:0] key_rd;

	mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::N_WORDS)) u_ram_a (
		.clk, .we, .waddr, .wdata, .raddr(ra_a), .rdata(rd_a));
	mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::N_WORDS)) u_ram_b (
		.clk, .we, .waddr, .wdata, .raddr(ra_b), .rdata(rd_b));
	mtg_ram #(.WIDTH(32), .DEPTH(mtg_pkg::N_WORDS)) u_ram_c (
		.clk, .we, .waddr, .wdata, .raddr(ra_c), .rdata(rd_c));
	mtg_ram #(.WIDTH(32), .DEPTH(KEY_MAX)) u_key_ram (
		.clk, .we(cmd.op == mtg_pkg::DOP_KEY), .waddr(cmd.key_idx[KW-1:0]),
		.wdata(cmd.key_word), .raddr(cmd.key_idx[KW-1:0]), .rdata(key_rd));

	// sequencing: the controller issues one command per word step, which the datapath
	// reads with idx, computes from the _s1 registers and writes from the _s2 registers.
	mtg_pkg::dp_op_t op_s1;
	logic [9:0]  idx_s1;
	logic [31:0] seed_s1;
	logic [9:0]  j_s1;
	logic        first_s1;
	logic [31:0] prev_q;
	logic [31:0] hash_s2;
	logic [31:0] mul_s2;
	mtg_pkg::dp_op_t op_s2;
	logic [9:0]  idx_s2;
	logic [31:0] base_s2;
	logic [31:0] add_s2;
	logic [31:0] p;
	logic [31:0] px;
	logic [9:0]  nxt_i;
	logic [9:0]  far_i;

	always_comb begin
		nxt_i = (cmd.idx == 10'(mtg_pkg::N_WORDS - 1)) ? 10'd0 : cmd.idx + 10'd1;
		far_i = (cmd.idx >= 10'(mtg_pkg::N_WORDS - mtg_pkg::M_OFF))
			? cmd.idx - 10'(mtg_pkg::N_WORDS - mtg_pkg::M_OFF)
			: cmd.idx + 10'(mtg_pkg::M_OFF);
		ra_a = cmd.idx;
		ra_b = nxt_i;
		ra_c = far_i;
		if (cmd.op == mtg_pkg::DOP_MIX1 || cmd.op == mtg_pkg::DOP_MIX2 ||
			cmd.op == mtg_pkg::DOP_SEED)
			ra_b = (cmd.idx == 10'd0) ? 10'(mtg_pkg::N_WORDS - 1) : cmd.idx - 10'd1;
	end

	always_ff @(posedge clk) begin
		op_s1    <= cmd.op;
		idx_s1   <= cmd.idx;
		seed_s1  <= cmd.seed;
		j_s1     <= cmd.j;
		first_s1 <= cmd.first;
	end

	// previous word: for the first step it comes from memory, then from the last write
	assign p  = first_s1 ? rd_b : prev_q;
	assign px = p ^ (p >> 30);

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		idx_s2 <= idx_s1;
		unique case (op_s1)
			mtg_pkg::DOP_SEED: begin
				mul_s2  <= px * mtg_pkg::INIT_MULT;
				base_s2 <= 32'd0;
				add_s2  <= 32'(idx_s1);
			end
			mtg_pkg::DOP_MIX1: begin
				mul_s2  <= px * mtg_pkg::MIX1_MULT;
				base_s2 <= rd_a;
				add_s2  <= key_rd + 32'(j_s1);
			end
			mtg_pkg::DOP_MIX2: begin
				mul_s2  <= px * mtg_pkg::MIX2_MULT;
				base_s2 <= rd_a;
				add_s2  <= -32'(idx_s1);
			end
			default: begin
				mul_s2  <= 32'd0;
				base_s2 <= mtg_pkg::twist(rd_a, rd_b, rd_c);
				add_s2  <= seed_s1;
			end
		endcase
		hash_s2 <= rd_a;
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_s2;
		wdata = (base_s2 ^ mul_s2) + add_s2;
		unique case (op_s2)
			mtg_pkg::DOP_SEED, mtg_pkg::DOP_MIX1, mtg_pkg::DOP_MIX2: we = 1'b1;
			mtg_pkg::DOP_TWIST: begin
				we    = 1'b1;
				wdata = base_s2;
			end
			mtg_pkg::DOP_W0: begin
				we    = 1'b1;
				wdata = add_s2;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk)
		if (we)
			prev_q <= wdata;

	assign stat.rd_word = mtg_pkg::temper(hash_s2);
endmodule

FILE: rtl/mtg_control.sv
// controller state machine of the mt19937 generator
// depends on mtg_pkg and assert_macros.svh
`include "assert_macros.svh"
module mtg_control #(
	parameter int KEY_MAX = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        opcode,
	input  logic [31:0]       value,
	input  logic              last_key,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       random_word,
	output mtg_pkg::dp_cmd_t  cmd,
	input  mtg_pkg::dp_stat_t stat
);
	localparam int N = mtg_pkg::N_WORDS;
	localparam int KCW = $clog2(KEY_MAX + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SEED  = 7'b0000010,
		S_MIX1  = 7'b0000100,
		S_MIX2  = 7'b0001000,
		S_MARK  = 7'b0010000,
		S_TWIST = 7'b0100000,
		S_READ  = 7'b1000000
	} state_t;

	localparam logic [1:0] THEN_DONE = 2'd0;
	localparam logic [1:0] THEN_MIX = 2'd1;
	localparam logic [1:0] THEN_TWIST = 2'd2;

	state_t      state_q;
	logic [9:0]  idx_q;       // word index of the current step
	logic [10:0] cnt_q;       // steps left
	logic [9:0]  rd_idx_q;    // read index, 625 means never seeded
	logic [KCW-1:0] key_count_q;
	logic [9:0]  j_q;
	logic        first_q;
	logic [1:0]  then_q;      // what follows a seed pass
	logic [1:0]  wait_q;
	logic [31:0] out_q;
	logic        out_v_q;
	logic [31:0] seed_q;
	logic        accept;
	logic        key_room;
	logic        step_done;
	logic        capture;
	logic [9:0]  mix_idx_nxt;
	logic [9:0]  j_nxt;

	assign accept = in_valid && in_ready;
	assign key_room = key_count_q < KCW'(KEY_MAX);
	assign in_ready = (state_q == S_IDLE) && (!out_v_q || out_ready);
	assign out_valid = out_v_q;
	assign random_word = out_q;
	assign step_done = (wait_q == 2'd2);
	assign capture = (state_q == S_READ) && step_done;
	assign mix_idx_nxt = (idx_q == 10'(N - 1)) ? 10'd1 : idx_q + 10'd1;
	assign j_nxt = (11'(j_q) + 11'd1 >= 11'(key_count_q)) ? '0 : j_q + 10'd1;

	always_comb begin
		cmd = '0;
		cmd.op = mtg_pkg::DOP_NONE;
		cmd.idx = idx_q;
		cmd.j = j_q;
		cmd.first = first_q;
		cmd.seed = seed_q;
		cmd.key_word = value;
		cmd.key_idx = 10'(key_count_q);
		unique case (state_q)
			S_IDLE: begin
				if (accept && opcode == mtg_pkg::OP_SALT && key_room)
					cmd.op = mtg_pkg::DOP_KEY;
			end
			S_SEED: begin
				if (wait_q == 2'd0) begin
					if (idx_q == 10'd0)
						cmd.op = mtg_pkg::DOP_W0;
					else
						cmd.op = mtg_pkg::DOP_SEED;
				end
			end
			S_MIX1: begin
				cmd.key_idx = j_q;
				if (wait_q == 2'd0)
					cmd.op = mtg_pkg::DOP_MIX1;
			end
			S_MIX2: begin
				if (wait_q == 2'd0)
					cmd.op = mtg_pkg::DOP_MIX2;
			end
			S_MARK: begin
				cmd.seed = mtg_pkg::HIGH_BIT;
				cmd.idx = 10'd0;
				if (wait_q == 2'd0)
					cmd.op = mtg_pkg::DOP_W0;
			end
			S_TWIST: begin
				if (wait_q == 2'd0)
					cmd.op = mtg_pkg::DOP_TWIST;
			end
			S_READ: begin
				cmd.idx = rd_idx_q;
				if (wait_q == 2'd0)
					cmd.op = mtg_pkg::DOP_READ;
			end
			default: ;
		endcase
	end

	// each word step goes through read, compute and write; wait_q counts these phases
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			cnt_q       <= '0;
			rd_idx_q    <= 10'(N + 1);
			key_count_q <= '0;
			j_q         <= '0;
			first_q     <= 1'b0;
			then_q      <= THEN_DONE;
			wait_q      <= '0;
			seed_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (opcode)
							mtg_pkg::OP_NEXT: begin
								if (rd_idx_q == 10'(N + 1)) begin
									seed_q <= mtg_pkg::DEFAULT_SEED;
									then_q <= THEN_TWIST;
									state_q <= S_SEED;
									idx_q <= '0;
									cnt_q <= 11'(N);
								end else if (rd_idx_q == 10'(N)) begin
									state_q <= S_TWIST;
									idx_q <= '0;
									cnt_q <= 11'(N);
								end else begin
									state_q <= S_READ;
								end
							end
							mtg_pkg::OP_SEED: begin
								seed_q <= value;
								then_q <= THEN_DONE;
								state_q <= S_SEED;
								idx_q <= '0;
								cnt_q <= 11'(N);
							end
							mtg_pkg::OP_SALT: begin
								if (key_room)
									key_count_q <= key_count_q + KCW'(1);
								if (last_key) begin
									if (rd_idx_q == 10'(N + 1)) begin
										seed_q <= mtg_pkg::DEFAULT_SEED;
										then_q <= THEN_MIX;
										state_q <= S_SEED;
										idx_q <= '0;
										cnt_q <= 11'(N);
									end else begin
										state_q <= S_MIX1;
										idx_q <= 10'd1;
										j_q <= '0;
										first_q <= 1'b1;
										cnt_q <= 11'(N);
									end
								end
							end
							default: ;
						endcase
					end
				end
				S_SEED: begin
					// word 0 takes the seed directly, then the recurrence
					wait_q <= step_done ? 2'd0 : wait_q + 2'd1;
					if (step_done) begin
						if (cnt_q == 11'd1) begin
							rd_idx_q <= 10'(N);
							if (then_q == THEN_MIX) begin
								state_q <= S_MIX1;
								idx_q <= 10'd1;
								j_q <= '0;
								first_q <= 1'b1;
								cnt_q <= 11'(N);
							end else if (then_q == THEN_TWIST) begin
								state_q <= S_TWIST;
								idx_q <= '0;
								cnt_q <= 11'(N);
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							idx_q <= idx_q + 10'd1;
							cnt_q <= cnt_q - 11'd1;
						end
					end
				end
				S_MIX1: begin
					wait_q <= step_done ? 2'd0 : wait_q + 2'd1;
					if (step_done) begin
						first_q <= 1'b0;
						idx_q <= mix_idx_nxt;
						j_q <= j_nxt;
						if (cnt_q == 11'd1) begin
							state_q <= S_MIX2;
							cnt_q <= 11'(N - 1);
						end else begin
							cnt_q <= cnt_q - 11'd1;
						end
					end
				end
				S_MIX2: begin
					wait_q <= step_done ? 2'd0 : wait_q + 2'd1;
					if (step_done) begin
						idx_q <= mix_idx_nxt;
						if (cnt_q == 11'd1) begin
							state_q <= S_MARK;
							key_count_q <= '0;
							rd_idx_q <= 10'(N);
						end else begin
							cnt_q <= cnt_q - 11'd1;
						end
					end
				end
				S_MARK: begin
					wait_q <= step_done ? 2'd0 : wait_q + 2'd1;
					if (step_done)
						state_q <= S_IDLE;
				end
				S_TWIST: begin
					wait_q <= step_done ? 2'd0 : wait_q + 2'd1;
					if (step_done) begin
						if (cnt_q == 11'd1) begin
							rd_idx_q <= '0;
							state_q <= S_READ;
						end else begin
							idx_q <= idx_q + 10'd1;
							cnt_q <= cnt_q - 11'd1;
						end
					end
				end
				S_READ: begin
					wait_q <= step_done ? 2'd0 : wait_q + 2'd1;
					if (step_done) begin
						rd_idx_q <= rd_idx_q + 10'd1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_q   <= '0;
		end else if (capture) begin
			out_v_q <= 1'b1;
			out_q   <= stat.rd_word;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_v_q && !out_ready, out_v_q && $stable(out_q))
	`ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == S_IDLE)
	`ASSERT_IMPL(a_keys_bound, clk, arst_n, 1'b1, key_count_q <= KCW'(KEY_MAX))
endmodule
